### sv/b64d_pkg.sv
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and helper functions of the base64 stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

    localparam int B64D_CHAR_W = 8;
    localparam int B64D_BYTE_W = 8;
    localparam int B64D_SEXT_W = 6;
    localparam int B64D_QDEPTH = 4;

    localparam logic [7:0] B64D_MASK_HI = 8'h30;
    localparam logic [7:0] B64D_MASK_LO = 8'h0f;
    localparam logic [7:0] B64D_MASK_MD = 8'h3c;
    localparam logic [7:0] B64D_MASK_BT = 8'h03;

    // up to three decoded bytes caused by one item; cnt is 1..3
    typedef struct packed {
        logic [2:0][B64D_BYTE_W-1:0] bytes;
        logic [1:0]                  cnt;
    } t_job;

    // bit 6 set: not in the alphabet (stop character)
    function automatic logic [6:0] sextet_of(input logic [7:0] ch);
        logic [6:0] r;
        r = 7'h40;
        if (ch >= 8'h41 && ch <= 8'h5a) begin
            r = {1'b0, 6'(ch - 8'h41)};
        end else if (ch >= 8'h61 && ch <= 8'h7a) begin
            r = {1'b0, 6'(ch - 8'h61 + 8'd26)};
        end else if (ch >= 8'h30 && ch <= 8'h39) begin
            r = {1'b0, 6'(ch - 8'h30 + 8'd52)};
        end else if (ch == 8'h2b) begin
            r = {1'b0, 6'd62};
        end else if (ch == 8'h2f) begin
            r = {1'b0, 6'd63};
        end
        return r;
    endfunction

    function automatic logic [2:0][7:0] pack_group(input logic [3:0][5:0] s);
        logic [2:0][7:0] b;
        logic [7:0]      s0, s1, s2, s3;
        s0 = {2'b00, s[0]};
        s1 = {2'b00, s[1]};
        s2 = {2'b00, s[2]};
        s3 = {2'b00, s[3]};
        b[0] = (s0 << 2) | ((s1 & B64D_MASK_HI) >> 4);
        b[1] = ((s1 & B64D_MASK_LO) << 4) | ((s2 & B64D_MASK_MD) >> 2);
        b[2] = ((s2 & B64D_MASK_BT) << 6) | s3;
        return b;
    endfunction

endpackage

### sv/b64d_if.sv
// ----------------------------------------------------------------------------
// b64d_if
// Valid/ready channels of the decoder: character in, byte out.
// ----------------------------------------------------------------------------
interface b64d_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_string;

    modport source (output valid, output char_code, output end_of_string, input ready);
    modport sink   (input valid, input char_code, input end_of_string, output ready);
endinterface

interface b64d_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       run_last;

    modport source (output valid, output data_byte, output run_last, input ready);
    modport sink   (input valid, input data_byte, input run_last, output ready);
endinterface

### sv/b64d_front.sv
// ----------------------------------------------------------------------------
// b64d_front
// Accepts characters, classifies them, keeps the group state and builds
// one byte job per item that causes output.
// ----------------------------------------------------------------------------
module b64d_front
    import b64d_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    b64d_char_if.sink      i_chr,
    input  logic           i_full,
    output logic           o_push,
    output t_job           o_job
);

    logic [2:0][5:0] r_store, n_store;
    logic [1:0]      r_cnt, n_cnt;
    logic            r_stop, n_stop;

    logic            acc;
    logic [6:0]      cls;
    logic            ok;
    logic [5:0]      v;
    logic [3:0][5:0] s;
    logic [1:0]      nbytes;

    assign i_chr.ready = !i_full;
    assign acc = i_chr.valid && !i_full;
    assign cls = sextet_of(i_chr.char_code);
    assign ok  = !cls[6];
    assign v   = cls[5:0];

    // group with the current sextet merged in at its slot
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            s[i] = (ok && r_cnt == 2'(i)) ? v : r_store[i];
        end
        s[3] = v;
    end

    always_comb begin
        n_store = r_store;
        n_cnt   = r_cnt;
        n_stop  = r_stop;
        nbytes  = 2'd0;
        if (acc) begin
            if (!r_stop) begin
                if (ok) begin
                    if (r_cnt == 2'd3) begin
                        nbytes = 2'd3;
                        n_cnt  = 2'd0;
                    end else begin
                        n_store[r_cnt] = v;
                        n_cnt          = r_cnt + 2'd1;
                        if (i_chr.end_of_string) begin
                            nbytes = r_cnt;
                        end
                    end
                end else begin
                    n_stop = 1'b1;
                    nbytes = (r_cnt == 2'd0) ? 2'd0 : r_cnt - 2'd1;
                    n_cnt  = 2'd0;
                end
            end
            if (i_chr.end_of_string) begin
                n_cnt  = 2'd0;
                n_stop = 1'b0;
            end
        end
    end

    assign o_push      = acc && (nbytes != 2'd0);
    assign o_job.bytes = pack_group(s);
    assign o_job.cnt   = nbytes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_store <= '0;
            r_cnt   <= 2'd0;
            r_stop  <= 1'b0;
        end else begin
            r_store <= n_store;
            r_cnt   <= n_cnt;
            r_stop  <= n_stop;
        end
    end

endmodule

### sv/b64d_fifo.sv
// ----------------------------------------------------------------------------
// b64d_fifo
// Short job queue between front and back.
// ----------------------------------------------------------------------------
module b64d_fifo
    import b64d_pkg::*;
#(
    parameter int DEPTH = B64D_QDEPTH,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_job          i_job,
    input  logic          i_pop,
    output t_job          o_head,
    output logic          o_full,
    output logic          o_empty,
    output logic [CW-1:0] o_count
);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          wr, rd;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;
    assign o_head  = r_mem[r_rp];
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (wr && !rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd && !wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

### sv/b64d_back.sv
// ----------------------------------------------------------------------------
// b64d_back
// Plays out the bytes of the head job, one per cycle while the output is
// ready, and retires the job with its last byte.
// ----------------------------------------------------------------------------
module b64d_back
    import b64d_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_job           i_head,
    input  logic           i_empty,
    output logic           o_pop,
    b64d_byte_if.source    o_byte
);

    logic [1:0] r_idx, n_idx;
    logic       last;
    logic       acc;

    assign last             = (r_idx == i_head.cnt - 2'd1);
    assign acc              = o_byte.valid && o_byte.ready;
    assign o_byte.valid     = !i_empty;
    assign o_byte.data_byte = i_head.bytes[r_idx];
    assign o_byte.run_last  = last;
    assign o_pop            = acc && last;

    always_comb begin
        n_idx = r_idx;
        if (acc) begin
            n_idx = last ? 2'd0 : r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
        end else begin
            r_idx <= n_idx;
        end
    end

endmodule

### sv/base64_stream_decoder.sv
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Streaming base64 decoder: one character in per item, decoded bytes out.
// ----------------------------------------------------------------------------
// Takes one character per cycle while the job queue (QDEPTH entries) has
// room; a character that completes or ends a group queues one job of one to
// three bytes, which leave from the queue head one byte per cycle while the
// output is ready, run_last marking the final byte of that character.
// Sustained input rate is one character per cycle, since four characters
// yield at most three bytes; input stalls only when the output side holds
// off long enough to fill the queue. The first '=' or other non-alphabet
// code stops decoding until the end_of_string character.
// ----------------------------------------------------------------------------
module base64_stream_decoder
    import b64d_pkg::*;
#(
    parameter int QDEPTH = B64D_QDEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    b64d_char_if.sink    i_chr,
    b64d_byte_if.source  o_byte
);

    localparam int CW = $clog2(QDEPTH + 1);

    logic          q_push;
    logic          q_pop;
    logic          q_full;
    logic          q_empty;
    t_job          job, head;
    logic [CW-1:0] q_count;

    b64d_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_chr   (i_chr),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_job   (job)
    );

    b64d_fifo #(.DEPTH(QDEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (job),
        .i_pop   (q_pop),
        .o_head  (head),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    b64d_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_empty (q_empty),
        .o_pop   (q_pop),
        .o_byte  (o_byte)
    );

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= CW'(QDEPTH))
        else $error("queue count above depth");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !i_chr.ready)
        else $error("input ready while queue full");

    a_pop_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> (o_byte.valid && o_byte.ready && o_byte.run_last))
        else $error("job retired without its last byte");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_push && !q_pop) |=> (q_count == $past(q_count) + 1'b1))
        else $error("queue count did not follow push");

endmodule
